// File: hw/rtl/radix_converter_assert.svh
// Assertion macros for the radix converter RTL.
// Expects clk and rst in the scope of the including module; no other dependencies.
`ifndef RADIX_CONVERTER_ASSERT_SVH
`define RADIX_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/rc_pkg.sv
// Shared constants, command codes and helper functions for the radix converter.
// No dependencies; used by rc_div and radix_converter.
package rc_pkg;

  localparam int VALUE_W    = 31;
  localparam int TEXT_W     = 64;
  localparam int LEN_W      = 4;
  localparam int BASE_W     = 4;
  localparam int DIGIT_W    = 4;
  localparam int TEXT_CHARS = 8;
  localparam int RECIP_W    = 32;
  localparam int PROD_W     = VALUE_W + RECIP_W;
  localparam int SUM_W      = VALUE_W + BASE_W;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 104;

  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
  localparam logic [BASE_W-1:0]  BASE_MIN  = 4'd2;
  localparam logic [BASE_W-1:0]  BASE_MAX  = 4'd10;

  typedef enum logic [1:0] {
    CMD_TO_BIN    = 2'd0,
    CMD_TO_DIGITS = 2'd1,
    CMD_TO_HEX    = 2'd2,
    CMD_FROM_HEX  = 2'd3
  } cmd_t;

  // floor(2^32 / d) for the divisors in use
  function automatic logic [RECIP_W-1:0] recip(input logic [BASE_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      4'd2:    r = 32'h8000_0000;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h4000_0000;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h2000_0000;
      4'd9:    r = 32'h1C71_C71C;
      4'd10:   r = 32'h1999_9999;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h41 + {4'h0, nib} - 8'd10;
    end
    return c;
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h41 + 8'd10);
    end else begin
      v = '0;
    end
    return v;
  endfunction

endpackage

// File: hw/rtl/rc_div.sv
// Shared divide-by-small-constant unit: reciprocal multiply, then one correction step.
// Depends on rc_pkg. Load phase registers the product, next cycle gives q and r.
module rc_div (
  input  logic                         clk,
  input  logic                         load,
  input  logic [rc_pkg::VALUE_W-1:0]   num,
  input  logic [rc_pkg::BASE_W-1:0]    divisor,
  output logic [rc_pkg::VALUE_W-1:0]   quot,
  output logic [rc_pkg::DIGIT_W-1:0]   rem
);

  logic [rc_pkg::PROD_W-1:0]  prod;
  logic [rc_pkg::VALUE_W-1:0] q0;
  logic [rc_pkg::VALUE_W+rc_pkg::BASE_W-1:0] qd;
  logic [rc_pkg::VALUE_W-1:0] r0;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= rc_pkg::PROD_W'(num) * rc_pkg::PROD_W'(rc_pkg::recip(divisor));
    end
  end

  // q0 is the true quotient or one below it
  always_comb begin
    q0 = prod[rc_pkg::PROD_W-1:rc_pkg::RECIP_W];
    qd = (rc_pkg::VALUE_W+rc_pkg::BASE_W)'(q0)
       * (rc_pkg::VALUE_W+rc_pkg::BASE_W)'(divisor);
    r0 = num - qd[rc_pkg::VALUE_W-1:0];
    if (r0 >= rc_pkg::VALUE_W'(divisor)) begin
      quot = q0 + 1'b1;
      rem  = rc_pkg::DIGIT_W'(r0 - rc_pkg::VALUE_W'(divisor));
    end else begin
      quot = q0;
      rem  = r0[rc_pkg::DIGIT_W-1:0];
    end
  end

endmodule

// File: hw/rtl/radix_converter.sv
// Accept to result valid: ops 0/1 step DIV_MUL, DIV_FIX per digit D peeled off by the
// divider (up to 10 for op 0, up to 31 for op 1 in base 2), a last DIV_MUL, then FINISH;
// op 2 steps HEX_FMT per hex char (1..8), op 3 HEX_PARSE per char of the clamped text_length.
// Ops 2/3 then end in FINISH. One item in flight; next taken after the result register loads.
// Synchronous active-high reset returns the sequencer to idle and clears m_axis_tvalid.
// Top level of the radix converter; depends on rc_pkg, rc_div and radix_converter_assert.svh.
`include "radix_converter_assert.svh"

module radix_converter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata, low bit up: number_in[30:0], base[34:31], text_in[98:35],
  // text_length[102:99], zero pad[103]
  input  logic [rc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata, low bit up: result_value[30:0], result_text[94:31],
  // result_length[98:95], overflow[99], zero pad[103:100]
  output logic [rc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MUL,
    ST_DIV_FIX,
    ST_HEX_FMT,
    ST_HEX_PARSE,
    ST_FINISH
  } state_t;

  state_t state;

  // item registers
  rc_pkg::cmd_t                    cmd;
  logic [rc_pkg::VALUE_W-1:0]      n;       // dividend, or nibble source for op 2
  logic [rc_pkg::BASE_W-1:0]       dv;      // divisor: 10 for op 0, base for op 1
  logic [rc_pkg::BASE_W-1:0]       wmul;    // weight step: base for op 0, 10 for op 1
  logic [rc_pkg::VALUE_W:0]        acc;     // 32 bits: op 3 parses up to 8 nibbles
  logic [rc_pkg::VALUE_W-1:0]      weight;
  logic                            wbig;    // weight has passed the value range
  logic                            pend;    // a digit waits to be accumulated
  logic [rc_pkg::DIGIT_W-1:0]      digit;
  logic                            ovf;
  logic [rc_pkg::TEXT_W-1:0]       text;
  logic [rc_pkg::LEN_W-1:0]        cnt;

  // input unpack
  logic [rc_pkg::VALUE_W-1:0]      in_number;
  logic [rc_pkg::BASE_W-1:0]       in_base;
  logic [rc_pkg::TEXT_W-1:0]       in_text;
  logic [rc_pkg::LEN_W-1:0]        in_len;
  logic [rc_pkg::BASE_W-1:0]       base_c;
  logic [rc_pkg::LEN_W-1:0]        len_c;
  rc_pkg::cmd_t                    in_cmd;

  // datapath
  logic [rc_pkg::SUM_W-1:0]        acc_sum;
  logic [rc_pkg::SUM_W-1:0]        w_prod;
  logic [rc_pkg::VALUE_W-1:0]      div_q;
  logic [rc_pkg::DIGIT_W-1:0]      div_r;
  logic [rc_pkg::VALUE_W-1:0]      n_shr;

  // result
  logic                            out_sat;
  logic [rc_pkg::VALUE_W-1:0]      out_value;
  logic [rc_pkg::TEXT_W-1:0]       out_text;
  logic [rc_pkg::LEN_W-1:0]        out_len;

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    in_number = s_axis_tdata[30:0];
    in_base   = s_axis_tdata[34:31];
    in_text   = s_axis_tdata[98:35];
    in_len    = s_axis_tdata[102:99];
    in_cmd    = rc_pkg::cmd_t'(s_axis_tuser);
    // out-of-range bases pin to the nearest legal one
    if (in_base < rc_pkg::BASE_MIN) begin
      base_c = rc_pkg::BASE_MIN;
    end else if (in_base > rc_pkg::BASE_MAX) begin
      base_c = rc_pkg::BASE_MAX;
    end else begin
      base_c = in_base;
    end
    if (in_len > rc_pkg::LEN_W'(rc_pkg::TEXT_CHARS)) begin
      len_c = rc_pkg::LEN_W'(rc_pkg::TEXT_CHARS);
    end else begin
      len_c = in_len;
    end
  end

  // shared divider: one digit per DIV_MUL/DIV_FIX pass
  rc_div u_div (
    .clk     (clk),
    .load    (state == ST_DIV_MUL),
    .num     (n),
    .divisor (dv),
    .quot    (div_q),
    .rem     (div_r)
  );

  // digit accumulate and weight step, both off registered values
  always_comb begin
    acc_sum = rc_pkg::SUM_W'(acc) + rc_pkg::SUM_W'(digit) * rc_pkg::SUM_W'(weight);
    w_prod  = rc_pkg::SUM_W'(weight) * rc_pkg::SUM_W'(wmul);
    n_shr   = n >> 4;
  end

  always_comb begin
    // acc[31] rises on op 3, or on ops 0/1 together with ovf; ops 0/1 hold acc in range unless ovf is set
    out_sat  = ovf | acc[rc_pkg::VALUE_W];
    if (out_sat && (cmd != rc_pkg::CMD_TO_HEX)) begin
      out_value = rc_pkg::VALUE_MAX;
    end else begin
      out_value = acc[rc_pkg::VALUE_W-1:0];
    end
    out_text = (cmd == rc_pkg::CMD_TO_HEX) ? text : '0;
    out_len  = (cmd == rc_pkg::CMD_TO_HEX) ? cnt  : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      // ST_FINISH always leaves tvalid high, so it owns tvalid in that state
      if (m_axis_tready && (state != ST_FINISH)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd    <= in_cmd;
            n      <= in_number;
            acc    <= '0;
            weight <= rc_pkg::VALUE_W'(1);
            wbig   <= 1'b0;
            pend   <= 1'b0;
            digit  <= '0;
            ovf    <= 1'b0;
            case (in_cmd)
              rc_pkg::CMD_TO_BIN: begin
                dv    <= rc_pkg::BASE_MAX;
                wmul  <= base_c;
                text  <= '0;
                cnt   <= '0;
                state <= ST_DIV_MUL;
              end
              rc_pkg::CMD_TO_DIGITS: begin
                dv    <= base_c;
                wmul  <= rc_pkg::BASE_MAX;
                text  <= '0;
                cnt   <= '0;
                state <= ST_DIV_MUL;
              end
              rc_pkg::CMD_TO_HEX: begin
                text  <= '0;
                cnt   <= '0;
                state <= ST_HEX_FMT;
              end
              default: begin
                text  <= in_text;
                cnt   <= len_c;
                state <= ST_HEX_PARSE;
              end
            endcase
          end
        end
        ST_DIV_MUL: begin
          if (pend) begin
            if (digit != '0) begin
              if (wbig) begin
                ovf <= 1'b1;
              end else begin
                if (acc_sum > rc_pkg::SUM_W'(rc_pkg::VALUE_MAX)) begin
                  ovf <= 1'b1;
                end
                acc <= acc_sum[rc_pkg::VALUE_W:0];
              end
            end
            // weight stops growing once past range; any later nonzero digit overflows
            if (!wbig) begin
              if (w_prod > rc_pkg::SUM_W'(rc_pkg::VALUE_MAX)) begin
                wbig <= 1'b1;
              end else begin
                weight <= w_prod[rc_pkg::VALUE_W-1:0];
              end
            end
            pend <= 1'b0;
          end
          if (n == '0) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_DIV_FIX;
          end
        end
        ST_DIV_FIX: begin
          n     <= div_q;
          digit <= div_r;
          pend  <= 1'b1;
          state <= ST_DIV_MUL;
        end
        ST_HEX_FMT: begin
          // low nibble first, inserted at the top: ends most significant first
          text <= {rc_pkg::hex_char(n[3:0]), text[rc_pkg::TEXT_W-1:8]};
          n    <= n_shr;
          cnt  <= cnt + 1'b1;
          if ((n_shr == '0) || (cnt == rc_pkg::LEN_W'(rc_pkg::TEXT_CHARS - 1))) begin
            ovf   <= (n_shr != '0);
            state <= ST_FINISH;
          end
        end
        ST_HEX_PARSE: begin
          if (cnt == '0) begin
            state <= ST_FINISH;
          end else begin
            acc  <= {acc[rc_pkg::VALUE_W-4:0],
                     rc_pkg::hex_value(text[rc_pkg::TEXT_W-1 -: 8])};
            text <= {text[rc_pkg::TEXT_W-9:0], 8'h00};
            cnt  <= cnt - 1'b1;
          end
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {4'b0000, out_sat, out_len, out_text, out_value};
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `RC_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after accept")
  `RC_ASSERT_NOW(a_div_rem_range, state == ST_DIV_FIX, div_r < dv, "divider remainder not below divisor")
  `RC_ASSERT_NOW(a_sat_value, m_axis_tvalid && (m_axis_tdata[98:95] == '0) && m_axis_tdata[99], m_axis_tdata[30:0] == rc_pkg::VALUE_MAX, "overflow without saturated value")
  `RC_ASSERT_NOW(a_no_text, m_axis_tvalid && (m_axis_tdata[98:95] == '0), m_axis_tdata[94:31] == '0, "text on a numeric result")

endmodule

// File: verif/tb.sv
// Self-checking bench for radix_converter: directed table, then constrained-random items.
// Results are predicted in-bench and checked in order; depends on rc_pkg and the RTL only.
module tb;
  import rc_pkg::*;

  // One conversion request, as the sender sees it
  typedef struct packed {
    cmd_t        cmd;
    logic [30:0] number;
    logic [3:0]  base;
    logic [63:0] text;
    logic [3:0]  text_len;
  } conv_req_t;

  // Field order matches m_axis_tdata[99:0], low bit last
  typedef struct packed {
    logic        ovf;
    logic [3:0]  len;
    logic [63:0] text;
    logic [30:0] value;
  } conv_res_t;

  // Directed row: request, whether the answer is typed in, and that answer
  typedef struct packed {
    conv_req_t req;
    logic      typed;
    conv_res_t want;
  } conv_row_t;

  localparam int RANDOM_ITEMS = 900;
  localparam int QUIET_TAIL   = 120;  // last items run with no idling
  localparam int HOLD_AT      = 400;  // sender drains all pending results here
  localparam conv_res_t NO_ANSWER = '0;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  conv_res_t results_due[$];   // predicted results, oldest first
  conv_row_t rows[$];          // directed table
  int        fail_count = 0;
  bit        quiet = 1'b0;     // no idling on either side
  string     hex_digits = "0123456789ABCDEF";

  radix_converter u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic conv_req_t op(cmd_t c, logic [30:0] num, logic [3:0] b,
                                   logic [63:0] t, logic [3:0] l);
    conv_req_t r;
    r.cmd = c;
    r.number = num;
    r.base = b;
    r.text = t;
    r.text_len = l;
    return r;
  endfunction

  function automatic conv_res_t answer(logic [30:0] v, logic o, logic [63:0] t,
                                       logic [3:0] l);
    conv_res_t a;
    a.value = v;
    a.ovf = o;
    a.text = t;
    a.len = l;
    return a;
  endfunction

  // Expected result of one conversion
  function automatic conv_res_t convert(conv_req_t r);
    conv_res_t   res;
    logic [63:0] num, radix, acc, weight, d, rest, dig;
    logic [7:0]  chars[8];
    logic [7:0]  ch;
    logic [3:0]  nib;
    int          n, tl;
    res = '0;
    num = 64'(r.number);
    // out-of-range base is pinned to 2..10
    if (r.base < 4'd2) radix = 64'd2;
    else if (r.base > 4'd10) radix = 64'd10;
    else radix = 64'(r.base);
    acc = 64'd0;
    weight = 64'd1;
    case (r.cmd)
      CMD_TO_BIN: begin
        // each decimal digit weighted by a power of the base, even if >= base
        while (num != 0) begin
          acc += (num % 10) * weight;
          num /= 10;
          weight *= radix;
        end
        if (acc > 64'(VALUE_MAX)) begin
          res.ovf = 1'b1;
          acc = 64'(VALUE_MAX);
        end
        res.value = acc[30:0];
      end
      CMD_TO_DIGITS: begin
        while (num != 0) begin
          d = num % radix;
          num /= radix;
          if (d != 0) begin
            if (weight > 64'(VALUE_MAX)) begin
              res.ovf = 1'b1;
            end else begin
              acc += d * weight;
              if (acc > 64'(VALUE_MAX)) res.ovf = 1'b1;
            end
          end
          if (weight <= 64'(VALUE_MAX)) weight *= 10;
        end
        res.value = res.ovf ? VALUE_MAX : acc[30:0];
      end
      CMD_TO_HEX: begin
        // least significant nibble first; zero still gives one character
        n = 0;
        rest = num;
        while (n == 0 || (rest != 0 && n < TEXT_CHARS)) begin
          nib = rest[3:0];
          chars[n] = hex_digits[nib];
          n++;
          rest >>= 4;
        end
        for (int k = 0; k < n; k++) res.text[63 - 8 * k -: 8] = chars[n - 1 - k];
        res.len = 4'(n);
      end
      default: begin
        tl = (r.text_len > TEXT_CHARS) ? TEXT_CHARS : int'(r.text_len);
        for (int k = 0; k < tl; k++) begin
          ch = r.text[63 - 8 * k -: 8];
          // anything outside 0-9 / A-F reads as zero
          if (ch >= "0" && ch <= "9") dig = 64'(ch - "0");
          else if (ch >= "A" && ch <= "F") dig = 64'(ch - "A") + 64'd10;
          else dig = 64'd0;
          acc = acc * 16 + dig;
        end
        if (acc > 64'(VALUE_MAX)) begin
          res.ovf = 1'b1;
          acc = 64'(VALUE_MAX);
        end
        res.value = acc[30:0];
      end
    endcase
    return res;
  endfunction

  task automatic flag_result(input string what, input conv_res_t want, input conv_res_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%s (exp/got): value %0d/%0d, text %h/%h, len %0d/%0d, ovf %0b/%0b",
               what, want.value, got.value, want.text, got.text, want.len, got.len,
               want.ovf, got.ovf);
  endtask

  // Present one item, hold it until taken, then record its expected result
  task automatic send_item(input conv_req_t r, input conv_res_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, r.text_len, r.text, r.base, r.number};
    s_axis_tuser  <= r.cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    results_due.push_back(want);
  endtask

  // Result side: check every accepted item, stall in random bursts
  initial begin : result_sink
    int        stall;
    conv_res_t got, want;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[99:0];
        if (results_due.size() == 0) begin
          flag_result("unexpected result", NO_ANSWER, got);
        end else begin
          want = results_due.pop_front();
          if (got.value !== want.value || got.text !== want.text ||
              got.len !== want.len || got.ovf !== want.ovf)
            flag_result("mismatch", want, got);
        end
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Request side
  initial begin : request_source
    conv_req_t r;
    conv_res_t want;
    int        total, dbase;
    bit        calm;
    logic [3:0] nib;

    // Directed table. Typed answers are the obvious ones; the rest use the predictor.
    // digits to binary: zero, all digits of the max, digit above base (29 in base 2 = 13)
    rows.push_back({op(CMD_TO_BIN, 31'd0, 4'd10, 64'd0, 4'd1), 1'b1,
                    answer(31'd0, 1'b0, 64'd0, 4'd0)});
    rows.push_back({op(CMD_TO_BIN, VALUE_MAX, 4'd10, 64'd0, 4'd1), 1'b1,
                    answer(VALUE_MAX, 1'b0, 64'd0, 4'd0)});
    rows.push_back({op(CMD_TO_BIN, 31'd29, 4'd2, 64'd0, 4'd1), 1'b1,
                    answer(31'd13, 1'b0, 64'd0, 4'd0)});
    rows.push_back({op(CMD_TO_BIN, 31'd123, 4'd15, 64'd0, 4'd1), 1'b1,
                    answer(31'd123, 1'b0, 64'd0, 4'd0)});
    rows.push_back({op(CMD_TO_BIN, 31'd1999999999, 4'd0, 64'd0, 4'd1), 1'b0, NO_ANSWER});
    rows.push_back({op(CMD_TO_BIN, 31'd1011, 4'd1, 64'd0, 4'd1), 1'b0, NO_ANSWER});
    // binary to digits: zero, binary saturation, exact fits, base clamps
    rows.push_back({op(CMD_TO_DIGITS, 31'd0, 4'd2, 64'd0, 4'd1), 1'b1,
                    answer(31'd0, 1'b0, 64'd0, 4'd0)});
    rows.push_back({op(CMD_TO_DIGITS, VALUE_MAX, 4'd2, 64'd0, 4'd1), 1'b1,
                    answer(VALUE_MAX, 1'b1, 64'd0, 4'd0)});
    rows.push_back({op(CMD_TO_DIGITS, 31'd255, 4'd2, 64'd0, 4'd1), 1'b1,
                    answer(31'd11111111, 1'b0, 64'd0, 4'd0)});
    rows.push_back({op(CMD_TO_DIGITS, 31'd1023, 4'd2, 64'd0, 4'd1), 1'b1,
                    answer(31'd1111111111, 1'b0, 64'd0, 4'd0)});
    rows.push_back({op(CMD_TO_DIGITS, 31'd1024, 4'd2, 64'd0, 4'd1), 1'b1,
                    answer(VALUE_MAX, 1'b1, 64'd0, 4'd0)});
    rows.push_back({op(CMD_TO_DIGITS, VALUE_MAX, 4'd10, 64'd0, 4'd1), 1'b1,
                    answer(VALUE_MAX, 1'b0, 64'd0, 4'd0)});
    rows.push_back({op(CMD_TO_DIGITS, 31'd12345, 4'd13, 64'd0, 4'd1), 1'b1,
                    answer(31'd12345, 1'b0, 64'd0, 4'd0)});
    rows.push_back({op(CMD_TO_DIGITS, 31'd1000, 4'd1, 64'd0, 4'd1), 1'b0, NO_ANSWER});
    // hex text out: zero gives "0", full width, mid value
    rows.push_back({op(CMD_TO_HEX, 31'd0, 4'd0, 64'd0, 4'd0), 1'b1,
                    answer(31'd0, 1'b0, 64'h3000_0000_0000_0000, 4'd1)});
    rows.push_back({op(CMD_TO_HEX, VALUE_MAX, 4'd15, {64{1'b1}}, 4'd15), 1'b1,
                    answer(31'd0, 1'b0, 64'h3746_4646_4646_4646, 4'd8)});
    rows.push_back({op(CMD_TO_HEX, 31'h000A_BCDE, 4'd10, 64'd0, 4'd1), 1'b0, NO_ANSWER});
    rows.push_back({op(CMD_TO_HEX, 31'h10, 4'd2, 64'd0, 4'd1), 1'b0, NO_ANSWER});
    // hex text in: max, saturation, partial length, lowercase, zero and long lengths
    rows.push_back({op(CMD_FROM_HEX, 31'd0, 4'd0, 64'h3746_4646_4646_4646, 4'd8), 1'b1,
                    answer(VALUE_MAX, 1'b0, 64'd0, 4'd0)});
    rows.push_back({op(CMD_FROM_HEX, 31'd0, 4'd0, 64'h4646_4646_4646_4646, 4'd8), 1'b1,
                    answer(VALUE_MAX, 1'b1, 64'd0, 4'd0)});
    rows.push_back({op(CMD_FROM_HEX, 31'd0, 4'd0, 64'h3141_FFFF_FFFF_FFFF, 4'd2), 1'b1,
                    answer(31'h1A, 1'b0, 64'd0, 4'd0)});
    rows.push_back({op(CMD_FROM_HEX, 31'd0, 4'd0, 64'h6162_0000_0000_0000, 4'd2), 1'b1,
                    answer(31'd0, 1'b0, 64'd0, 4'd0)});
    rows.push_back({op(CMD_FROM_HEX, VALUE_MAX, 4'd0, 64'h3132_3334_3536_3738, 4'd0), 1'b1,
                    answer(31'd0, 1'b0, 64'd0, 4'd0)});
    rows.push_back({op(CMD_FROM_HEX, 31'd0, 4'd0, 64'h3132_3334_3536_3738, 4'd15), 1'b1,
                    answer(31'h1234_5678, 1'b0, 64'd0, 4'd0)});
    rows.push_back({op(CMD_FROM_HEX, 31'd0, 4'd0, 64'h4739_403A_2F47_6046, 4'd9), 1'b0,
                    NO_ANSWER});

    total = rows.size() + RANDOM_ITEMS;
    calm = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < total; i++) begin
      if (i < rows.size()) begin
        r = rows[i].req;
        want = rows[i].typed ? rows[i].want : convert(r);
      end else begin
        r.cmd = cmd_t'($urandom_range(0, 3));
        // mostly legal bases, sometimes the whole field
        r.base = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(2, 10));
        dbase = (r.base < 4'd2) ? 2 : (r.base > 4'd10) ? 10 : int'(r.base);
        case ($urandom_range(0, 4))
          0: r.number = 31'($urandom);
          1: r.number = 31'($urandom_range(0, 999));
          2: r.number = VALUE_MAX >> $urandom_range(0, 30);
          3: r.number = VALUE_MAX - 31'($urandom_range(0, 15));
          default: begin
            // decimal string whose digits are legal in the base
            r.number = '0;
            repeat ($urandom_range(1, 9))
              r.number = r.number * 10 + 31'($urandom_range(0, dbase - 1));
          end
        endcase
        if ($urandom_range(0, 7) == 0) begin
          r.text = {$urandom, $urandom};
        end else begin
          for (int k = 0; k < 8; k++) begin
            nib = 4'($urandom);
            r.text[8 * k +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : hex_digits[nib];
          end
        end
        r.text_len = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        want = convert(r);
        if (i % 100 == 0) calm = ($urandom_range(0, 2) == 0);
        if (i == total - QUIET_TAIL) quiet = 1'b1;
      end

      // let the pipe drain completely once
      if (i == HOLD_AT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0) @(posedge clk);
      end

      send_item(r, want);

      if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b0;

    // bounded wait for the tail; anything left is reported missing
    for (int w = 0; w < 5000 && results_due.size() != 0; w++) @(posedge clk);
    repeat (100) @(posedge clk);
    while (results_due.size() != 0) flag_result("missing result", results_due.pop_front(),
                                                NO_ANSWER);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
